>>> hw/rtl/assert_macros.svh
// Assertion macros for the parser RTL.
// Checks compile away when SYNTHESIS is defined; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SCLP_CHECK_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("parser check failed");
`define SCLP_CHECK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("parser check failed");
`else
`define SCLP_CHECK_IMPL(lbl, clk, rst, ante, cons)
`define SCLP_CHECK_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> hw/rtl/sclp_pkg.sv
// Package for the serial command line parser: state, configuration and
// result types plus character constants. No dependencies.
package sclp_pkg;

   localparam int unsigned MAX_DIGITS_DEFAULT = 5;
   localparam logic [2:0]  PREFIX_MAX         = 3'd4;

   localparam logic [7:0] LINE_FEED  = 8'h0A;
   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] DIGIT_LO   = 8'h30;
   localparam logic [7:0] DIGIT_HI   = 8'h39;

   // Letter slots inside pending flags.
   localparam int unsigned LETTER_ADDR  = 4;
   localparam int unsigned LETTER_VALUE = 5;
   localparam int unsigned LETTER_COUNT = 6;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PREFIX_CHARS  = 2'd0;
   localparam logic [1:0] CSR_PREFIX_LENGTH = 2'd1;
   localparam logic [1:0] CSR_LEAD_CHAR     = 2'd2;
   localparam logic [1:0] CSR_FLAG_LETTERS  = 2'd3;

   localparam logic [31:0] PREFIX_CHARS_RESET  = 32'd101;
   localparam logic [2:0]  PREFIX_LENGTH_RESET = 3'd1;
   localparam logic [7:0]  LEAD_CHAR_RESET     = 8'd45;
   localparam logic [47:0] FLAG_LETTERS_RESET  = 48'd130160668275319;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_FLAG = 2'd1,
      ST_DATA = 2'd2
   } parse_state_type;

   typedef enum logic [1:0] {
      TGT_NONE  = 2'd0,
      TGT_ADDR  = 2'd1,
      TGT_VALUE = 2'd2
   } target_type;

   typedef struct packed {
      parse_state_type parse_state;
      logic [2:0]      byte_count;
      target_type      param_target;
      logic            digit_seen;
      logic [5:0]      pending_flags;
      logic [15:0]     address_acc;
      logic [15:0]     value_acc;
      logic            address_digit;
      logic            value_digit;
      logic            timer_armed;
   } parser_state_type;

   typedef struct packed {
      logic [31:0] prefix_chars;
      logic [2:0]  prefix_length;
      logic [7:0]  lead_char;
      logic [47:0] flag_letters;
   } parser_cfg_type;

   typedef struct packed {
      logic        status;
      logic [5:0]  flags;
      logic        address_has_digits;
      logic        data_has_digits;
      logic [15:0] address;
      logic [15:0] data_value;
   } parser_result_type;

endpackage

>>> hw/rtl/sclp_step.sv
// Next-state and result logic for one received byte or timeout event.
// Purely combinational; depends on sclp_pkg.
module sclp_step #(
   parameter int unsigned MAX_DIGITS = sclp_pkg::MAX_DIGITS_DEFAULT
) (
   input  sclp_pkg::parser_state_type  cur_state,
   input  sclp_pkg::parser_cfg_type    cfg,
   input  logic                        action,
   input  logic [7:0]                  rx_byte,
   output sclp_pkg::parser_state_type  nxt_state,
   output logic                        emit,
   output sclp_pkg::parser_result_type result
);
   import sclp_pkg::*;

   logic [2:0]  prefix_len;
   logic [7:0]  want_char;
   logic [2:0]  count_inc;
   logic [2:0]  letter_idx;
   logic        letter_hit;
   logic        is_digit;
   logic [3:0]  digit;
   logic        do_line;
   logic        do_error;

   assign prefix_len = (cfg.prefix_length > PREFIX_MAX) ? PREFIX_MAX : cfg.prefix_length;
   assign want_char  = cfg.prefix_chars[8*cur_state.byte_count[1:0] +: 8];
   assign count_inc  = cur_state.byte_count + 3'd1;
   assign is_digit   = (rx_byte >= DIGIT_LO) && (rx_byte <= DIGIT_HI);
   assign digit      = rx_byte[3:0];

   // First match wins, so scan from the last slot down.
   always_comb begin
      letter_idx = 3'd0;
      letter_hit = 1'b0;
      for (int k = LETTER_COUNT - 1; k >= 0; k--) begin
         if (cfg.flag_letters[8*k +: 8] == rx_byte) begin
            letter_idx = 3'(k);
            letter_hit = 1'b1;
         end
      end
   end

   always_comb begin
      nxt_state = cur_state;
      do_line   = 1'b0;
      do_error  = 1'b0;
      if (action) begin
         do_error = cur_state.timer_armed;
      end else begin
         nxt_state.timer_armed = 1'b1;
         unique case (cur_state.parse_state)
            ST_IDLE: begin
               nxt_state.byte_count = (rx_byte == want_char) ? count_inc : 3'd0;
               if (nxt_state.byte_count >= prefix_len) begin
                  nxt_state.parse_state   = ST_FLAG;
                  nxt_state.byte_count    = 3'd0;
                  nxt_state.pending_flags = '0;
               end
            end
            ST_FLAG: begin
               if (cur_state.byte_count == 3'd0) begin
                  if (rx_byte == cfg.lead_char) begin
                     nxt_state.byte_count = 3'd1;
                  end else if (rx_byte == LINE_FEED) begin
                     do_line = 1'b1;
                  end else if (rx_byte != BLANK_CHAR) begin
                     do_error = 1'b1;
                  end
               end else if (!letter_hit) begin
                  do_error = 1'b1;
               end else begin
                  nxt_state.pending_flags[letter_idx] = 1'b1;
                  nxt_state.byte_count = 3'd0;
                  if (letter_idx == 3'(LETTER_ADDR)) begin
                     nxt_state.param_target  = TGT_ADDR;
                     nxt_state.address_acc   = '0;
                     nxt_state.address_digit = 1'b0;
                     nxt_state.parse_state   = ST_DATA;
                     nxt_state.digit_seen    = 1'b0;
                  end else if (letter_idx == 3'(LETTER_VALUE)) begin
                     nxt_state.param_target  = TGT_VALUE;
                     nxt_state.value_acc     = '0;
                     nxt_state.value_digit   = 1'b0;
                     nxt_state.parse_state   = ST_DATA;
                     nxt_state.digit_seen    = 1'b0;
                  end else begin
                     nxt_state.param_target  = TGT_NONE;
                  end
               end
            end
            ST_DATA: begin
               if (rx_byte == cfg.lead_char) begin
                  nxt_state.byte_count  = 3'd1;
                  nxt_state.parse_state = ST_FLAG;
               end else if (rx_byte == BLANK_CHAR) begin
                  if (cur_state.digit_seen) begin
                     nxt_state.byte_count  = 3'd0;
                     nxt_state.parse_state = ST_FLAG;
                  end
               end else if (rx_byte == LINE_FEED) begin
                  do_line = 1'b1;
               end else if (is_digit) begin
                  nxt_state.digit_seen = 1'b1;
                  if (cur_state.byte_count >= 3'(MAX_DIGITS)) begin
                     do_error = 1'b1;
                  end else begin
                     // acc * 10 + d, wrapping at 16 bits.
                     if (cur_state.param_target == TGT_ADDR) begin
                        nxt_state.address_acc = (cur_state.address_acc << 3)
                           + (cur_state.address_acc << 1) + 16'(digit);
                        nxt_state.address_digit = 1'b1;
                     end else if (cur_state.param_target == TGT_VALUE) begin
                        nxt_state.value_acc = (cur_state.value_acc << 3)
                           + (cur_state.value_acc << 1) + 16'(digit);
                        nxt_state.value_digit = 1'b1;
                     end
                     nxt_state.byte_count = count_inc;
                  end
               end else begin
                  do_error = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      if (do_error) begin
         nxt_state.parse_state   = ST_IDLE;
         nxt_state.byte_count    = 3'd0;
         nxt_state.pending_flags = '0;
         nxt_state.timer_armed   = 1'b0;
      end else if (do_line) begin
         nxt_state.parse_state   = ST_IDLE;
         nxt_state.byte_count    = 3'd0;
         nxt_state.timer_armed   = 1'b0;
      end
   end

   always_comb begin
      result = '0;
      if (do_error) begin
         result.status = 1'b1;
      end else begin
         result.flags = cur_state.pending_flags;
         if (cur_state.pending_flags[LETTER_ADDR]) begin
            result.address_has_digits = cur_state.address_digit;
            result.address            = cur_state.address_acc;
         end
         if (cur_state.pending_flags[LETTER_VALUE]) begin
            result.data_has_digits = cur_state.value_digit;
            result.data_value      = cur_state.value_acc;
         end
      end
   end

   assign emit = do_line || do_error;

endmodule

>>> hw/rtl/serial_command_line_parser_top.sv
// Serial command line parser: an accepted input beat is held in the input register and its
// result in the result register that drives rsp_tvalid; one beat is accepted every cycle while
// results drain. The rate is set by the combinational parser state update between those registers.
// Synchronous active-high reset returns the parser to idle, disarms the timer
// and loads the configuration registers with their default values.
// Depends on sclp_pkg, sclp_step and assert_macros.svh.
`include "assert_macros.svh"

module serial_command_line_parser_top #(
   parameter int unsigned MAX_DIGITS = sclp_pkg::MAX_DIGITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // Input stream: one received byte or one timeout event per beat.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] action (1 = timeout expired)
   // Result stream: one beat per completed line or bus error.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [0] want_write, [1] want_read, [2] want_erase,
                                    // [3] want_dump, [4] address_given,
                                    // [5] data_given, [6] address_has_digits,
                                    // [7] data_has_digits, [23:8] address,
                                    // [39:24] data_value
   output logic        rsp_tuser,   // [0] status (1 = bus error)
   // Configuration write channel.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_data
);
   import sclp_pkg::*;

   // The input register holds one beat; it moves on into the parser
   // whenever the result register is empty or being emptied.
   logic              in_valid_ff;
   logic              in_action_ff;
   logic [7:0]        in_byte_ff;
   logic              advance;

   parser_state_type  state_ff;
   parser_state_type  state_in;
   parser_cfg_type    cfg_ff;
   parser_cfg_type    cfg_in;

   logic              step_emit;
   parser_result_type step_result;
   logic              rsp_load;

   logic              rsp_valid_ff;
   parser_result_type rsp_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= req_tuser;
         in_byte_ff   <= req_tdata;
      end
   end

   // Configuration is to be written only while the parser is quiet; the block does not check.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PREFIX_CHARS:  cfg_in.prefix_chars  = csr_data[31:0];
            CSR_PREFIX_LENGTH: cfg_in.prefix_length = csr_data[2:0];
            CSR_LEAD_CHAR:     cfg_in.lead_char     = csr_data[7:0];
            CSR_FLAG_LETTERS:  cfg_in.flag_letters  = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prefix_chars  <= PREFIX_CHARS_RESET;
         cfg_ff.prefix_length <= PREFIX_LENGTH_RESET;
         cfg_ff.lead_char     <= LEAD_CHAR_RESET;
         cfg_ff.flag_letters  <= FLAG_LETTERS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sclp_step #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_step (
      .cur_state (state_ff),
      .cfg       (cfg_ff),
      .action    (in_action_ff),
      .rx_byte   (in_byte_ff),
      .nxt_state (state_in),
      .emit      (step_emit),
      .result    (step_result)
   );

   assign rsp_load = in_valid_ff && advance && step_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{parse_state: ST_IDLE, param_target: TGT_NONE, default: '0};
      end else if (in_valid_ff && advance) begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {rsp_ff.data_value, rsp_ff.address, rsp_ff.data_has_digits,
                        rsp_ff.address_has_digits, rsp_ff.flags};

   // A completed line or a bus error always leaves the parser idle and disarmed.
   `SCLP_CHECK_NEXT(a_idle_after_result, clock, reset, rsp_load, state_ff.parse_state == ST_IDLE)
   `SCLP_CHECK_NEXT(a_disarm_after_result, clock, reset, rsp_load, !state_ff.timer_armed)
   // A bus error carries no flags or numbers.
   `SCLP_CHECK_IMPL(a_error_clean, clock, reset, rsp_valid_ff && rsp_ff.status, rsp_tdata == '0)
   // Digit counting never runs past the configured limit.
   `SCLP_CHECK_IMPL(a_digit_limit, clock, reset, state_ff.parse_state == ST_DATA,
                    state_ff.byte_count <= 3'(MAX_DIGITS))
   // A held input beat is not dropped while the result side stalls.
   `SCLP_CHECK_NEXT(a_hold_input, clock, reset, in_valid_ff && !advance, in_valid_ff)

endmodule

>>> tb/serial_command_line_parser_top_test.sv
// Self-checking testbench for serial_command_line_parser_top: a directed table
// followed by random command lines under several register settings.
// Depends on sclp_pkg and the parser RTL; nothing else is read or needed.
module serial_command_line_parser_top_test;
   import sclp_pkg::*;

   localparam int unsigned HALF_PERIOD   = 10;
   localparam int unsigned RESET_CYCLES  = 6;
   // A beat passes through the input and result registers, so this settle time is
   // enough for a beat that produces no result to clear the pipeline.
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned RUN_LIMIT     = 500000;
   localparam int unsigned RANDOM_BEATS  = 1850;
   localparam int unsigned DIGIT_LIMIT   = MAX_DIGITS_DEFAULT;
   localparam int unsigned REPORT_LIMIT  = 10;

   // How a row of the directed table is checked. Typed rows carry their
   // expected report in the table, silent rows must produce no report, and
   // the rest are checked against the parse predictor.
   typedef enum logic [1:0] {
      ROW_PREDICT = 2'd0,
      ROW_SILENT  = 2'd1,
      ROW_TYPED   = 2'd2
   } row_kind_type;

   typedef struct packed {
      logic              timeout;
      logic [7:0]        ch;
      row_kind_type      kind;
      parser_result_type typed;
   } directed_row_type;

   localparam parser_result_type NO_FIELDS = '0;
   localparam parser_result_type BUS_ERROR = '{status: 1'b1, default: '0};
   localparam parser_result_type MAX_ADDR_LINE = '{
      status: 1'b0, flags: 6'b010001, address_has_digits: 1'b1,
      data_has_digits: 1'b0, address: 16'hFFFF, data_value: 16'h0000};

   // The directed part runs with the reset register values: prefix "e",
   // dash as the flag character and the letters w, r, e, d, a, v.
   localparam int unsigned DIRECTED_COUNT = 25;
   localparam directed_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // A timeout right after reset finds the timer disarmed.
      '{1'b1, 8'h00,      ROW_SILENT,  NO_FIELDS},
      '{1'b0, "e",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "-",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "w",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "-",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "a",        ROW_PREDICT, NO_FIELDS},
      // The largest address that fits in five digits and sixteen bits.
      '{1'b0, "6",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "5",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "5",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "3",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "5",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, LINE_FEED,  ROW_TYPED,   MAX_ADDR_LINE},
      // Every remaining letter, then a value flag whose leading space is
      // ignored and which ends the line without digits.
      '{1'b0, "e",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "-",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "r",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "-",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "e",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "-",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "d",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "-",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, "v",        ROW_PREDICT, NO_FIELDS},
      '{1'b0, BLANK_CHAR, ROW_PREDICT, NO_FIELDS},
      '{1'b0, LINE_FEED,  ROW_PREDICT, NO_FIELDS},
      // A timeout once the prefix has armed the timer is a bus error.
      '{1'b0, "e",        ROW_PREDICT, NO_FIELDS},
      '{1'b1, 8'h00,      ROW_TYPED,   BUS_ERROR}
   };

   // Register values for the random phases after the first one, which runs
   // on the reset values. Between them they cover a full four-character
   // prefix, a length above the maximum, a zero length, all-zero and
   // all-one characters and letters, duplicated letters, and a flag
   // character equal to line feed or to space. The last entry writes the
   // reset values back.
   localparam int unsigned CFG_COUNT = 7;
   localparam parser_cfg_type CFG_PLAN [CFG_COUNT] = '{
      '{32'h44434241, 3'd4, 8'h2D,      FLAG_LETTERS_RESET},
      '{32'hFFFFFFFF, 3'd7, 8'h00,      48'hFFFF_FFFF_FFFF},
      '{32'h00000000, 3'd0, 8'hFF,      48'h0000_0000_0000},
      '{32'h00006261, 3'd2, LINE_FEED,  48'h7661_6465_7277},
      '{32'h00646D63, 3'd3, BLANK_CHAR, 48'h7661_7879_7877},
      '{32'h00000021, 3'd1, 8'h2F,      48'h5641_4445_5257},
      '{PREFIX_CHARS_RESET, PREFIX_LENGTH_RESET, LEAD_CHAR_RESET, FLAG_LETTERS_RESET}
   };
   localparam int unsigned PHASE_BEATS = RANDOM_BEATS / (CFG_COUNT + 1);

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [47:0] csr_data;

   serial_command_line_parser_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Predictor copy of the registers and of the parser state.
   parser_cfg_type   model_cfg;
   parser_state_type model_st;

   // Reports (completed lines and bus errors) still to come from the block.
   parser_result_type awaited_reports [$];

   // Beats of the command line being sent: bit 8 marks a timeout event.
   logic [8:0] line_beats [$];

   int unsigned beats_sent  = 0;
   int unsigned failures    = 0;
   int unsigned cycle_count = 0;
   int          send_calm   = 0;
   int          take_calm   = 0;

   // Wait before a beat: mostly a random gap, with occasional stretches
   // of back-to-back beats.
   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(39) == 0) begin
         calm_left = $urandom_range(60, 20);
         return 0;
      end
      return $urandom_range(10);
   endfunction

   function automatic void report_bus_error(output parser_result_type res);
      res = BUS_ERROR;
      model_st.parse_state   = ST_IDLE;
      model_st.byte_count    = '0;
      model_st.pending_flags = '0;
      model_st.timer_armed   = 1'b0;
   endfunction

   // A finished line reports its flags; a parameter whose flag was not
   // given reads as zero, whatever its accumulator holds.
   function automatic void report_line(output parser_result_type res);
      res = NO_FIELDS;
      res.flags = model_st.pending_flags;
      if (model_st.pending_flags[LETTER_ADDR]) begin
         res.address_has_digits = model_st.address_digit;
         res.address            = model_st.address_acc;
      end
      if (model_st.pending_flags[LETTER_VALUE]) begin
         res.data_has_digits = model_st.value_digit;
         res.data_value      = model_st.value_acc;
      end
      model_st.parse_state = ST_IDLE;
      model_st.byte_count  = '0;
      model_st.timer_armed = 1'b0;
   endfunction

   // Advances the predicted parser by one beat. Returns 1 when the beat
   // produces a report, which is then left in res.
   function automatic bit parse_beat(input logic timeout, input logic [7:0] c,
                                     output parser_result_type res);
      logic [2:0]  span;
      logic [7:0]  want;
      int unsigned slot;
      res = NO_FIELDS;
      if (timeout) begin
         if (model_st.timer_armed) begin
            report_bus_error(res);
            return 1'b1;
         end
         return 1'b0;
      end
      model_st.timer_armed = 1'b1;
      span = (model_cfg.prefix_length > PREFIX_MAX) ? PREFIX_MAX : model_cfg.prefix_length;
      case (model_st.parse_state)
         ST_IDLE: begin
            // A mismatch restarts the count without trying the byte again
            // as the first prefix character.
            want = model_cfg.prefix_chars[8*model_st.byte_count[1:0] +: 8];
            model_st.byte_count = model_st.byte_count + 3'd1;
            if (c != want) model_st.byte_count = '0;
            if (model_st.byte_count >= span) begin
               model_st.parse_state   = ST_FLAG;
               model_st.byte_count    = '0;
               model_st.pending_flags = '0;
            end
         end
         ST_FLAG: begin
            if (model_st.byte_count == 3'd0) begin
               // The flag character is tested ahead of line feed and space.
               if (c == model_cfg.lead_char) begin
                  model_st.byte_count = 3'd1;
               end else if (c == LINE_FEED) begin
                  report_line(res);
                  return 1'b1;
               end else if (c != BLANK_CHAR) begin
                  report_bus_error(res);
                  return 1'b1;
               end
            end else begin
               // Scan downward so that the lowest matching letter wins.
               slot = LETTER_COUNT;
               for (int k = LETTER_COUNT - 1; k >= 0; k--) begin
                  if (model_cfg.flag_letters[8*k +: 8] == c) slot = k;
               end
               if (slot == LETTER_COUNT) begin
                  report_bus_error(res);
                  return 1'b1;
               end
               model_st.pending_flags[slot] = 1'b1;
               model_st.byte_count = '0;
               if (slot == LETTER_ADDR) begin
                  model_st.param_target  = TGT_ADDR;
                  model_st.address_acc   = '0;
                  model_st.address_digit = 1'b0;
                  model_st.parse_state   = ST_DATA;
                  model_st.digit_seen    = 1'b0;
               end else if (slot == LETTER_VALUE) begin
                  model_st.param_target = TGT_VALUE;
                  model_st.value_acc    = '0;
                  model_st.value_digit  = 1'b0;
                  model_st.parse_state  = ST_DATA;
                  model_st.digit_seen   = 1'b0;
               end else begin
                  model_st.param_target = TGT_NONE;
               end
            end
         end
         ST_DATA: begin
            if (c == model_cfg.lead_char) begin
               model_st.byte_count  = 3'd1;
               model_st.parse_state = ST_FLAG;
            end else if (c == BLANK_CHAR) begin
               // A space ahead of the first digit is simply skipped.
               if (model_st.digit_seen) begin
                  model_st.byte_count  = '0;
                  model_st.parse_state = ST_FLAG;
               end
            end else if (c == LINE_FEED) begin
               report_line(res);
               return 1'b1;
            end else if (c >= DIGIT_LO && c <= DIGIT_HI) begin
               model_st.digit_seen = 1'b1;
               if (model_st.byte_count >= DIGIT_LIMIT) begin
                  report_bus_error(res);
                  return 1'b1;
               end
               if (model_st.param_target == TGT_ADDR) begin
                  model_st.address_acc   = model_st.address_acc * 16'd10 + 16'(c - DIGIT_LO);
                  model_st.address_digit = 1'b1;
               end else if (model_st.param_target == TGT_VALUE) begin
                  model_st.value_acc   = model_st.value_acc * 16'd10 + 16'(c - DIGIT_LO);
                  model_st.value_digit = 1'b1;
               end
               model_st.byte_count = model_st.byte_count + 3'd1;
            end else begin
               report_bus_error(res);
               return 1'b1;
            end
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic void note_failure(input string what, input parser_result_type want,
                                        input parser_result_type got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%s: expected status=%0b flags=%06b adig=%0b ddig=%0b addr=%0d data=%0d",
                  what, want.status, want.flags, want.address_has_digits,
                  want.data_has_digits, want.address, want.data_value);
         $display("   got status=%0b flags=%06b adig=%0b ddig=%0b addr=%0d data=%0d",
                  got.status, got.flags, got.address_has_digits, got.data_has_digits,
                  got.address, got.data_value);
      end
   endfunction

   // Sends one input beat; called and returning at a falling edge. The
   // expected report is queued at the rising edge that accepts the beat,
   // well ahead of the report itself.
   task automatic send_beat(input logic timeout, input logic [7:0] ch,
                            input row_kind_type kind, input parser_result_type typed);
      int                gap;
      bit                produced;
      parser_result_type predicted;
      gap = draw_wait(send_calm);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= timeout;
      req_tdata  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      produced = parse_beat(timeout, ch, predicted);
      if (kind == ROW_TYPED) begin
         awaited_reports.push_back(typed);
      end else if (kind == ROW_PREDICT && produced) begin
         awaited_reports.push_back(predicted);
      end
      beats_sent++;
      @(negedge clock);
   endtask

   // Stops the input stream until every awaited report has come, then
   // lets extra cycles pass. The loop always advances at least one edge,
   // so a following beat never raises req_tvalid in the same step.
   task automatic hold_until_drained(input int unsigned extra);
      req_tvalid <= 1'b0;
      do @(negedge clock); while (awaited_reports.size() != 0);
      repeat (extra) @(negedge clock);
   endtask

   // Writes one register and keeps csr_valid high for a write that follows.
   task automatic write_reg(input logic [1:0] index, input logic [47:0] word);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= word;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         CSR_PREFIX_CHARS:  model_cfg.prefix_chars  = word[31:0];
         CSR_PREFIX_LENGTH: model_cfg.prefix_length = word[2:0];
         CSR_LEAD_CHAR:     model_cfg.lead_char     = word[7:0];
         CSR_FLAG_LETTERS:  model_cfg.flag_letters  = word;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic apply_cfg(input parser_cfg_type next);
      write_reg(CSR_PREFIX_CHARS, {16'd0, next.prefix_chars});
      write_reg(CSR_PREFIX_LENGTH, {45'd0, next.prefix_length});
      write_reg(CSR_LEAD_CHAR, {40'd0, next.lead_char});
      write_reg(CSR_FLAG_LETTERS, next.flag_letters);
      csr_valid <= 1'b0;
   endtask

   // Builds a command line for the current registers: prefix, up to four
   // flags with their parameters, and a line feed. Now and then the
   // prefix is disturbed, a parameter overruns its digit limit, a beat is
   // replaced by a random byte, or the line is cut short by a timeout.
   task automatic plan_command();
      int unsigned span;
      int unsigned slot;
      int unsigned digit_total;
      int unsigned cut;
      logic        all_nines;
      line_beats.delete();
      span = (model_cfg.prefix_length > PREFIX_MAX) ? PREFIX_MAX : model_cfg.prefix_length;
      if ($urandom_range(9) == 0) line_beats.push_back({1'b0, 8'($urandom)});
      if (span == 0) begin
         line_beats.push_back({1'b0, 8'($urandom)});
      end else if ($urandom_range(9) == 0) begin
         // A doubled first character can break the match on the second one.
         line_beats.push_back({1'b0, model_cfg.prefix_chars[7:0]});
      end
      for (int i = 0; i < span; i++) begin
         line_beats.push_back({1'b0, model_cfg.prefix_chars[8*i +: 8]});
      end
      repeat ($urandom_range(4)) begin
         if ($urandom_range(2) == 0) line_beats.push_back({1'b0, BLANK_CHAR});
         line_beats.push_back({1'b0, model_cfg.lead_char});
         slot = $urandom_range(LETTER_COUNT - 1);
         line_beats.push_back({1'b0, model_cfg.flag_letters[8*slot +: 8]});
         if (slot >= LETTER_ADDR) begin
            if ($urandom_range(3) == 0) line_beats.push_back({1'b0, BLANK_CHAR});
            digit_total = ($urandom_range(9) == 0) ? DIGIT_LIMIT + 1 : $urandom_range(DIGIT_LIMIT);
            all_nines = ($urandom_range(4) == 0);
            repeat (digit_total) begin
               line_beats.push_back({1'b0, all_nines ? DIGIT_HI : DIGIT_LO + 8'($urandom_range(9))});
            end
         end
      end
      line_beats.push_back({1'b0, LINE_FEED});
      case ($urandom_range(9))
         0: begin
            line_beats[$urandom_range(line_beats.size() - 1)] = {1'b0, 8'($urandom)};
         end
         1: begin
            cut = $urandom_range(line_beats.size() - 1);
            while (line_beats.size() > cut) void'(line_beats.pop_back());
            line_beats.push_back({1'b1, 8'($urandom)});
         end
         default: ;
      endcase
   endtask

   // One random phase: mostly well-formed command lines, with bursts of
   // random bytes and timeouts, lone timeouts, and pauses until drained.
   task automatic run_phase(input int unsigned quota);
      int unsigned start;
      start = beats_sent;
      while (beats_sent - start < quota) begin
         case ($urandom_range(19))
            0, 1: begin
               repeat ($urandom_range(8, 1)) begin
                  send_beat($urandom_range(7) == 0, 8'($urandom), ROW_PREDICT, NO_FIELDS);
               end
            end
            2: begin
               send_beat(1'b1, 8'($urandom), ROW_PREDICT, NO_FIELDS);
            end
            3: begin
               hold_until_drained(0);
            end
            default: begin
               plan_command();
               foreach (line_beats[i]) begin
                  send_beat(line_beats[i][8], line_beats[i][7:0], ROW_PREDICT, NO_FIELDS);
               end
            end
         endcase
      end
   endtask

   // The result side draws a stall before every report and then holds
   // rsp_tready high until a report beat is taken.
   initial begin : result_taker
      int stall;
      rsp_tready <= 1'b0;
      forever begin
         @(negedge clock);
         stall = draw_wait(take_calm);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // Every accepted report beat is compared with the oldest awaited one.
   always @(posedge clock) begin : report_check
      parser_result_type got;
      parser_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.status             = rsp_tuser;
         got.flags              = rsp_tdata[5:0];
         got.address_has_digits = rsp_tdata[6];
         got.data_has_digits    = rsp_tdata[7];
         got.address            = rsp_tdata[23:8];
         got.data_value         = rsp_tdata[39:24];
         if (awaited_reports.size() == 0) begin
            note_failure("report with none awaited", NO_FIELDS, got);
         end else begin
            want = awaited_reports.pop_front();
            if (got.status !== want.status || got.flags !== want.flags ||
                got.address_has_digits !== want.address_has_digits ||
                got.data_has_digits !== want.data_has_digits ||
                got.address !== want.address || got.data_value !== want.data_value) begin
               note_failure("report mismatch", want, got);
            end
         end
      end
   end

   // A run that hangs, for instance on a report that never comes, ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("serial_command_line_parser_top test failed");
         $finish;
      end
   end

   initial begin
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_PREFIX_CHARS;
      csr_data   <= '0;
      reset      <= 1'b1;
      model_cfg = '{PREFIX_CHARS_RESET, PREFIX_LENGTH_RESET, LEAD_CHAR_RESET,
                    FLAG_LETTERS_RESET};
      model_st  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The directed table runs on the reset register values.
      foreach (DIRECTED_ROWS[r]) begin
         send_beat(DIRECTED_ROWS[r].timeout, DIRECTED_ROWS[r].ch, DIRECTED_ROWS[r].kind,
                   DIRECTED_ROWS[r].typed);
      end
      run_phase(PHASE_BEATS);

      // Registers change only once the block is idle: every awaited report
      // has come and any beat that produced none has left the pipeline.
      foreach (CFG_PLAN[p]) begin
         hold_until_drained(SETTLE_CYCLES);
         apply_cfg(CFG_PLAN[p]);
         run_phase(PHASE_BEATS);
      end

      hold_until_drained(SETTLE_CYCLES);
      if (failures == 0 && awaited_reports.size() == 0) begin
         $display("serial_command_line_parser_top test passed");
      end else begin
         $display("serial_command_line_parser_top test failed");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/sclp_pkg.sv
hw/rtl/sclp_step.sv
hw/rtl/serial_command_line_parser_top.sv
tb/serial_command_line_parser_top_test.sv
